/* design/trqkr_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// trqkr_pkg: shared types and constants for the thread ready queue
// Operation and status codes, request token control and default sizes.
// ---------------------------------------------------------------------------
package trqkr_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SRCH = 2'd2,
        OP_REM  = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    // control part of the request token walking the cell row
    typedef struct packed {
        logic valid;
        t_op  op;
        logic found;    // match found, or free slot filled on enqueue
    } t_tok;

endpackage
`default_nettype wire

/* design/thread_ready_queue_keyed_removal.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// thread_ready_queue_keyed_removal: FIFO run queue with search/remove by id
// A row of QUEUE_DEPTH cells, head at cell 0; each request token walks the
// row one cell per cycle and a result is formed when it leaves the tail.
// ---------------------------------------------------------------------------
// One request is in the row at a time; start is taken again in the strobe
// cycle, when busy has fallen. This is set by the token walking the cell row.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (synchronous, active low) empties the queue at once; no clearing pass.
module thread_ready_queue_keyed_removal #(
    parameter int QUEUE_DEPTH = trqkr_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = trqkr_pkg::ID_BITS_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [trqkr_pkg::OP_W-1:0]         i_op,
    input  wire  [trqkr_pkg::KEY_W-1:0]        i_thread_id,
    input  wire  [trqkr_pkg::HANDLE_W-1:0]     i_thread_handle,
    output logic                               o_strobe,
    output logic [trqkr_pkg::STATUS_W-1:0]     o_status,
    output logic [trqkr_pkg::HANDLE_W-1:0]     o_handle_out,
    output logic [CNT_W-1:0]                   o_entry_count
);

    trqkr_pkg::t_tok                tok  [QUEUE_DEPTH+1];
    logic [ID_BITS-1:0]             key  [QUEUE_DEPTH+1];
    logic [trqkr_pkg::HANDLE_W-1:0] hnd  [QUEUE_DEPTH+1];
    logic [trqkr_pkg::HANDLE_W-1:0] fhnd [QUEUE_DEPTH+1];

    logic                           bk_load [QUEUE_DEPTH+1];
    logic [ID_BITS-1:0]             bk_id   [QUEUE_DEPTH+1];
    logic [trqkr_pkg::HANDLE_W-1:0] bk_hnd  [QUEUE_DEPTH+1];

    logic                           r_busy;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic                           r_strobe;
    trqkr_pkg::t_status             r_status;
    trqkr_pkg::t_status             n_status;
    logic [trqkr_pkg::HANDLE_W-1:0] r_handle;
    logic                           accept;
    logic                           done;
    logic                           fin_enq;

    // request enters the head cell
    assign accept = start && !r_busy;
    assign done   = tok[QUEUE_DEPTH].valid;

    always_comb begin
        tok[0].valid = accept;
        tok[0].op    = trqkr_pkg::t_op'(i_op);
        tok[0].found = 1'b0;
        key[0]       = ID_BITS'(i_thread_id);
        hnd[0]       = i_thread_handle;
        fhnd[0]      = '0;
    end

    // nothing moves in past the tail
    assign bk_load[QUEUE_DEPTH] = 1'b0;
    assign bk_id[QUEUE_DEPTH]   = '0;
    assign bk_hnd[QUEUE_DEPTH]  = '0;

    // cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        trqkr_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .i_key       (key[g]),
            .i_hnd       (hnd[g]),
            .i_fhnd      (fhnd[g]),
            .o_tok       (tok[g+1]),
            .o_key       (key[g+1]),
            .o_hnd       (hnd[g+1]),
            .o_fhnd      (fhnd[g+1]),
            .i_back_load (bk_load[g+1]),
            .i_back_id   (bk_id[g+1]),
            .i_back_hnd  (bk_hnd[g+1]),
            .o_back_load (bk_load[g]),
            .o_back_id   (bk_id[g]),
            .o_back_hnd  (bk_hnd[g])
        );
    end

    // result of the token leaving the tail
    always_comb begin
        fin_enq = (tok[QUEUE_DEPTH].op == trqkr_pkg::OP_ENQ);
        n_count = r_count;
        if (tok[QUEUE_DEPTH].found) begin
            n_status = trqkr_pkg::STAT_DONE;
        end else if (fin_enq) begin
            n_status = trqkr_pkg::STAT_FULL;
        end else begin
            n_status = trqkr_pkg::STAT_MISS;
        end
        unique case (tok[QUEUE_DEPTH].op)
            trqkr_pkg::OP_ENQ: begin
                if (tok[QUEUE_DEPTH].found) n_count = r_count + CNT_W'(1);
            end
            trqkr_pkg::OP_DEQ, trqkr_pkg::OP_REM: begin
                if (tok[QUEUE_DEPTH].found) n_count = r_count - CNT_W'(1);
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // control and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= done;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_status <= n_status;
            r_handle <= fhnd[QUEUE_DEPTH];
        end
    end

    assign busy          = r_busy;
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_handle_out  = r_handle;
    assign o_entry_count = r_count;

endmodule
`default_nettype wire

/* design/trqkr_cell.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// trqkr_cell: one queue position
// Holds one entry, handles the request token as it passes and hands it on,
// and pushes its entry one place toward the head after a removal.
// ---------------------------------------------------------------------------
module trqkr_cell #(
    parameter int ID_BITS = trqkr_pkg::ID_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // token from the head side
    input  trqkr_pkg::t_tok                   i_tok,
    input  wire  [ID_BITS-1:0]                i_key,
    input  wire  [trqkr_pkg::HANDLE_W-1:0]    i_hnd,
    input  wire  [trqkr_pkg::HANDLE_W-1:0]    i_fhnd,
    // token to the tail side
    output trqkr_pkg::t_tok                   o_tok,
    output logic [ID_BITS-1:0]                o_key,
    output logic [trqkr_pkg::HANDLE_W-1:0]    o_hnd,
    output logic [trqkr_pkg::HANDLE_W-1:0]    o_fhnd,
    // entry moving in from the tail side neighbor
    input  wire                               i_back_load,
    input  wire  [ID_BITS-1:0]                i_back_id,
    input  wire  [trqkr_pkg::HANDLE_W-1:0]    i_back_hnd,
    // entry moving out to the head side neighbor
    output logic                              o_back_load,
    output logic [ID_BITS-1:0]                o_back_id,
    output logic [trqkr_pkg::HANDLE_W-1:0]    o_back_hnd
);

    logic                           r_valid;
    logic [ID_BITS-1:0]             r_id;
    logic [trqkr_pkg::HANDLE_W-1:0] r_hnd;

    trqkr_pkg::t_tok                r_tok;
    trqkr_pkg::t_tok                n_tok;
    logic [ID_BITS-1:0]             r_key;
    logic [trqkr_pkg::HANDLE_W-1:0] r_thnd;
    logic [trqkr_pkg::HANDLE_W-1:0] r_fhnd;

    logic is_enq;
    logic is_take;
    logic hit;
    logic enq_hit;
    logic shift;

    // decode what the passing request does here
    always_comb begin
        is_enq  = (i_tok.op == trqkr_pkg::OP_ENQ);
        is_take = (i_tok.op == trqkr_pkg::OP_DEQ) || (i_tok.op == trqkr_pkg::OP_REM);
        hit     = i_tok.valid && !is_enq && !i_tok.found && r_valid
                  && ((i_tok.op == trqkr_pkg::OP_DEQ) || (r_id == i_key));
        enq_hit = i_tok.valid && is_enq && !i_tok.found && !r_valid;
        shift   = i_tok.valid && is_take && i_tok.found && r_valid;
        n_tok       = i_tok;
        n_tok.found = i_tok.found || hit || enq_hit;
    end

    // entry handed toward the head to close the gap
    assign o_back_load = shift;
    assign o_back_id   = r_id;
    assign o_back_hnd  = r_hnd;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_back_load) begin
            r_valid <= 1'b1;
        end else if (enq_hit) begin
            r_valid <= 1'b1;
        end else if ((hit && is_take) || shift) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_back_load) begin
            r_id  <= i_back_id;
            r_hnd <= i_back_hnd;
        end else if (enq_hit) begin
            r_id  <= i_key;
            r_hnd <= i_hnd;
        end
    end

    // token stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_thnd <= i_hnd;
        r_fhnd <= hit ? r_hnd : i_fhnd;
    end

    assign o_tok  = r_tok;
    assign o_key  = r_key;
    assign o_hnd  = r_thnd;
    assign o_fhnd = r_fhnd;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the thread ready queue
// Drives enqueue, dequeue, search and remove requests through start/busy,
// keeps a shadow queue that predicts status, handle and count for every
// accepted request, and compares each strobed result against the oldest
// prediction. Directed corner cases come first, then random traffic under
// several sender idle patterns.
// ---------------------------------------------------------------------------
module tb_top;
    import trqkr_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int ID_BITS     = ID_BITS_DEF;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [KEY_W-1:0] ID_MASK = KEY_W'((64'd1 << ID_BITS) - 1);
    localparam int MAX_PRINTED = 100;

    typedef struct {
        t_status               status;
        logic [HANDLE_W-1:0]   handle;
        logic [CNT_W-1:0]      count;
    } queue_result_t;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   start           = 1'b0;
    logic [OP_W-1:0]        i_op            = '0;
    logic [KEY_W-1:0]       i_thread_id     = '0;
    logic [HANDLE_W-1:0]    i_thread_handle = '0;
    wire                    busy;
    wire                    o_strobe;
    wire  [STATUS_W-1:0]    o_status;
    wire  [HANDLE_W-1:0]    o_handle_out;
    wire  [CNT_W-1:0]       o_entry_count;

    // shadow copy of the queue contents
    logic [KEY_W-1:0]       shadow_ids [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]    shadow_handles [QUEUE_DEPTH];
    int                     shadow_count;

    queue_result_t          expected_results [$];
    int                     err_count = 0;
    int                     idle_pct  = 0;

    thread_ready_queue_keyed_removal #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_thread_id     (i_thread_id),
        .i_thread_handle (i_thread_handle),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_handle_out    (o_handle_out),
        .o_entry_count   (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    // position of the first entry from the head with this id, -1 if none
    function automatic int find_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_ids[i] == key) return i;
        end
        return -1;
    endfunction

    // take out one entry and close the gap toward the head
    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_ids[i]     = shadow_ids[i + 1];
            shadow_handles[i] = shadow_handles[i + 1];
        end
        shadow_count--;
    endfunction

    // applies one request to the shadow queue and returns its result
    function automatic queue_result_t apply_queue_op(input t_op op,
                                                     input logic [KEY_W-1:0] id,
                                                     input logic [HANDLE_W-1:0] handle);
        queue_result_t    r;
        logic [KEY_W-1:0] key;
        int               pos;
        key      = id & ID_MASK;
        r.status = STAT_DONE;
        r.handle = '0;
        case (op)
            OP_ENQ: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_ids[shadow_count]     = key;
                    shadow_handles[shadow_count] = handle;
                    shadow_count++;
                end
            end
            OP_DEQ: begin
                if (shadow_count == 0) begin
                    r.status = STAT_MISS;
                end else begin
                    r.handle = shadow_handles[0];
                    drop_entry(0);
                end
            end
            OP_SRCH: begin
                pos = find_key(key);
                if (pos < 0) r.status = STAT_MISS;
                else r.handle = shadow_handles[pos];
            end
            default: begin
                pos = find_key(key);
                if (pos < 0) begin
                    r.status = STAT_MISS;
                end else begin
                    r.handle = shadow_handles[pos];
                    drop_entry(pos);
                end
            end
        endcase
        r.count = CNT_W'(shadow_count);
        return r;
    endfunction

    // send one request, wait for it to be taken, then maybe go idle
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] id,
                                input logic [HANDLE_W-1:0] handle);
        start           <= 1'b1;
        i_op            <= op;
        i_thread_id     <= id;
        i_thread_handle <= handle;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(apply_queue_op(op, id, handle));
        if ($urandom_range(99) < idle_pct) begin
            // idle gap with junk on the payload
            start           <= 1'b0;
            i_op            <= OP_W'($urandom);
            i_thread_id     <= KEY_W'($urandom);
            i_thread_handle <= HANDLE_W'($urandom);
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        queue_result_t exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result strobe with no request pending");
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_status, exp_r.status));
                if (o_handle_out !== exp_r.handle)
                    report_mismatch($sformatf("handle got %h expected %h",
                                              o_handle_out, exp_r.handle));
                if (o_entry_count !== exp_r.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              o_entry_count, exp_r.count));
            end
        end
    end

    // operations on an empty queue
    task automatic test_empty_queue();
        send_request(OP_DEQ, 16'h0000, 16'hFFFF);
        send_request(OP_SRCH, 16'h0000, 16'h0000);
        send_request(OP_REM, 16'hFFFF, 16'hFFFF);
    endtask

    // fill with extreme and duplicate ids, then push once more when full
    task automatic test_fill_to_full();
        send_request(OP_ENQ, 16'h0000, 16'hFFFF);
        send_request(OP_ENQ, 16'hFFFF, 16'h0000);
        send_request(OP_ENQ, 16'h0005, 16'hA5A5);
        send_request(OP_ENQ, 16'h0005, 16'h5A5A);
        for (int i = 4; i < QUEUE_DEPTH; i++) begin
            send_request(OP_ENQ, KEY_W'(16'h0100 + i), HANDLE_W'(16'h1000 + i));
        end
        send_request(OP_ENQ, 16'h1234, 16'h4321);
    endtask

    // keyed lookups and removals, then a dequeue, starting from the full queue
    task automatic test_keyed_ops();
        send_request(OP_SRCH, 16'h0005, 16'h0000);
        send_request(OP_SRCH, 16'hABCD, 16'h0000);
        send_request(OP_REM, 16'h0005, 16'h0000);
        send_request(OP_SRCH, 16'h0005, 16'h0000);
        send_request(OP_REM, 16'hFFFF, 16'h0000);
        send_request(OP_REM, KEY_W'(16'h0100 + QUEUE_DEPTH - 1), 16'h0000);
        send_request(OP_REM, 16'hABCD, 16'h0000);
        send_request(OP_DEQ, 16'h0000, 16'h0000);
    endtask

    // key for search/remove: mostly a held id, else a small pool or anything
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (shadow_count > 0 && r < 60)
            return shadow_ids[$urandom_range(shadow_count - 1)];
        if (r < 85)
            return KEY_W'($urandom_range(7));
        return KEY_W'($urandom);
    endfunction

    // random traffic that swings between filling and draining
    task automatic test_random_traffic(input int pct, input int n_items);
        t_op              op;
        logic [KEY_W-1:0] id;
        int               enq_pct;
        idle_pct = pct;
        for (int n = 0; n < n_items; n++) begin
            enq_pct = ((n / 40) % 2 == 0) ? 70 : 25;
            if ($urandom_range(99) < enq_pct) begin
                op = OP_ENQ;
                id = ($urandom_range(1) == 0) ? KEY_W'($urandom_range(7))
                                              : KEY_W'($urandom);
            end else begin
                case ($urandom_range(2))
                    0:       op = OP_DEQ;
                    1:       op = OP_SRCH;
                    default: op = OP_REM;
                endcase
                id = (op == OP_DEQ) ? KEY_W'($urandom) : pick_key();
            end
            send_request(op, id, HANDLE_W'($urandom));
        end
        idle_pct = 0;
    endtask

    initial begin
        shadow_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_to_full();
        test_keyed_ops();
        test_random_traffic(0, 357);
        test_random_traffic(82, 357);
        test_random_traffic(0, 357);
        test_random_traffic(36, 357);

        // drain outstanding results, then let the row settle
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (QUEUE_DEPTH + 4) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
